FILE: sv/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// When ante holds at one edge, cons must hold at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/blid_pkg.sv
`default_nettype none

package blid_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT    = 2'd0,
    MODE_DEL_FRONT = 2'd1,
    MODE_DEL_LAST  = 2'd2,
    MODE_DEL_POS   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_WORK = 1'b1
  } fsm_e;

  // Command broadcast to every cell of the chain for one item.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

endpackage

`default_nettype wire

FILE: sv/blid_cell.sv
`default_nettype none

module blid_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = 4
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  blid_pkg::cell_cmd_t          cmd_i,
  input  wire  [IDX_W-1:0]             del_idx_i,
  input  wire  [blid_pkg::DataW-1:0]   left_i,
  input  wire  [blid_pkg::DataW-1:0]   right_i,
  output logic [blid_pkg::DataW-1:0]   data_o,
  output logic [blid_pkg::DataW-1:0]   removed_o
);
  import blid_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DataW-1:0] data_q, data_d;
  logic [DataW-1:0] rm_q, rm_d;

  always_comb begin
    data_d = data_q;
    rm_d   = '0;
    if (cmd_i.ins) begin
      data_d = left_i;
    end else if (cmd_i.del) begin
      // Cells at or behind the deleted slot take their successor's entry.
      if (MyIdx >= del_idx_i) begin
        data_d = right_i;
      end
      if (MyIdx == del_idx_i) begin
        rm_d = data_q;
      end
    end
  end

  // The removed entry lives for one cycle only, so a failed item reads zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
      rm_q   <= '0;
    end else begin
      data_q <= data_d;
      rm_q   <= rm_d;
    end
  end

  assign data_o    = data_q;
  assign removed_o = rm_q;

endmodule

`default_nettype wire

FILE: sv/bounded_list_insert_delete.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------
// command  | in        | start && !busy     | mode_i, value_i, position_i
// result   | out       | done_o (one cycle) | status_o, entry_count_o, removed_value_o
//
// For each item, the chain of cells shifts in the accept cycle, and the
// removed entry is gathered from the cells and registered in the following cycle.
// busy is high for the cycle after an accept; the result strobe comes in the next
// cycle, when a new item may already be accepted.
// Reset clears every cell to zero and empties the list; no clearing pass is needed.
// The receiver cannot stall, so results never wait.
`default_nettype none

`include "assert_macros.svh"

module bounded_list_insert_delete #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire  [1:0]                        mode_i,
  input  wire  signed [blid_pkg::DataW-1:0] value_i,
  input  wire  [blid_pkg::CountW-1:0]       position_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [blid_pkg::CountW-1:0]       entry_count_o,
  output logic signed [blid_pkg::DataW-1:0] removed_value_o
);
  import blid_pkg::*;

  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned LEN_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CMP_W = (LEN_W > CountW) ? LEN_W : CountW;
  localparam logic [LEN_W-1:0] Full = LEN_W'(LIST_DEPTH);

  fsm_e state_q, state_d;

  logic [LEN_W-1:0] len_q, len_d;
  status_e          stat_q, stat_d;
  status_e          res_stat_q;
  logic [DataW-1:0] res_rm_q;
  logic             done_q;

  cell_cmd_t        cmd;
  logic [IDX_W-1:0] del_idx;
  logic             accept;
  logic [CMP_W-1:0] len_cmp, pos_cmp;
  logic [DataW-1:0] gathered;

  logic [DataW-1:0] cell_data [LIST_DEPTH];
  logic [DataW-1:0] cell_rm   [LIST_DEPTH];

  assign accept  = start && (state_q == FSM_IDLE);
  assign len_cmp = CMP_W'(len_q);
  assign pos_cmp = CMP_W'(position_i);

  always_comb begin
    state_d = state_q;
    busy    = (state_q == FSM_WORK);
    case (state_q)
      FSM_IDLE: if (start) state_d = FSM_WORK;
      FSM_WORK: state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // Decode the command and its status; the list changes only on success.
  always_comb begin
    cmd     = '0;
    del_idx = '0;
    len_d   = len_q;
    stat_d  = STAT_DONE;
    if (mode_e'(mode_i) == MODE_INSERT) begin
      if (len_q == Full) begin
        stat_d = STAT_FULL;
      end else begin
        cmd.ins = 1'b1;
        len_d   = len_q + LEN_W'(1);
      end
    end else if (len_q == '0) begin
      stat_d = STAT_EMPTY;
    end else begin
      case (mode_e'(mode_i))
        MODE_DEL_FRONT: begin
          cmd.del = 1'b1;
        end
        MODE_DEL_LAST: begin
          cmd.del = 1'b1;
          del_idx = IDX_W'(len_q - LEN_W'(1));
        end
        MODE_DEL_POS: begin
          if (position_i == '0 || pos_cmp > len_cmp) begin
            stat_d = STAT_BADPOS;
          end else begin
            cmd.del = 1'b1;
            del_idx = IDX_W'(position_i - CountW'(1));
          end
        end
        default: stat_d = STAT_DONE;
      endcase
      if (cmd.del) begin
        len_d = len_q - LEN_W'(1);
      end
    end
    if (!accept) begin
      cmd   = '0;
      len_d = len_q;
    end
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = value_i;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_data[i+1];
    end
    blid_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .del_idx_i (del_idx),
      .left_i    (left),
      .right_i   (right),
      .data_o    (cell_data[i]),
      .removed_o (cell_rm[i])
    );
  end

  // At most one cell holds a nonzero removed entry, so an OR gathers it.
  always_comb begin
    gathered = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      gathered = gathered | cell_rm[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      len_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      done_q  <= (state_q == FSM_WORK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stat_q <= stat_d;
    end
    if (state_q == FSM_WORK) begin
      res_stat_q <= stat_q;
      res_rm_q   <= gathered;
    end
  end

  logic [CMP_W-1:0] len_out;
  assign len_out         = CMP_W'(len_q);
  assign done_o          = done_q;
  assign status_o        = res_stat_q;
  assign entry_count_o   = len_out[CountW-1:0];
  assign removed_value_o = res_rm_q;

  `ASSERT_ALWAYS(a_len_bound, clk_i, rst_ni, len_q <= Full)
  `ASSERT_NEXT(a_work_then_done, clk_i, rst_ni, state_q == FSM_WORK, done_o)
  `ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, accept && cmd.ins, len_q == $past(len_q) + LEN_W'(1))
  `ASSERT_NEXT(a_delete_shrinks, clk_i, rst_ni, accept && cmd.del, len_q == $past(len_q) - LEN_W'(1))
  `ASSERT_ALWAYS(a_fail_no_removed, clk_i, rst_ni, !(done_o && status_o != STAT_DONE) || removed_value_o == '0)

endmodule

`default_nettype wire
